/* hdl/mdcd_pkg.sv */
// shared widths, codes and structs for the coherence directory
`timescale 1ns / 1ps
package mdcd_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int DEV_W    = 3;
    localparam int ST_W     = 2;
    localparam int VER_W    = 32;
    localparam int RDR_W    = 16;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 4;

    // default device count and reset value of the device-count register
    localparam int MAX_DEVICES_DEF = 8;
    localparam logic [CFG_W-1:0] CFG_NUM_DEV_RST = 4'd8;

    // coherence states
    localparam logic [ST_W-1:0] CS_INVALID   = 2'd0;
    localparam logic [ST_W-1:0] CS_SHARED    = 2'd1;
    localparam logic [ST_W-1:0] CS_EXCLUSIVE = 2'd2;
    localparam logic [ST_W-1:0] CS_OWNED     = 2'd3;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ATTACH  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DETACH  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SET     = 2'd2;
    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STS_NO_COPY   = 2'd1;
    localparam logic [STAT_W-1:0] STS_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STS_NO_SOURCE = 2'd3;

    // one directory entry as kept in the entry memory
    typedef struct packed {
        logic [ST_W-1:0]  state;
        logic [VER_W-1:0] version;
        logic [RDR_W-1:0] readers;
    } t_entry;

    // what the scan unit needs to know about the acquiring copy
    typedef struct packed {
        logic [ST_W-1:0]  cs;
        logic [VER_W-1:0] cver;
        logic             rd;
        logic             wr;
    } t_scan_ctrl;

    // scan unit verdict for one visited entry
    typedef struct packed {
        logic [ST_W-1:0] new_state;
        logic            valid_src;
        logic            owned_newer;
        logic            clr_owner;
    } t_scan_res;

    // result payload apart from the owner record
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              xfer;
        logic [DEV_W-1:0]  src;
        logic [ST_W-1:0]   state;
        logic [VER_W-1:0]  version;
        logic [RDR_W-1:0]  readers;
    } t_result;

endpackage

/* hdl/mdcd_req_if.sv */
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface mdcd_req_if import mdcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DEV_W-1:0]  device;
    logic              read_access;
    logic              write_access;
    logic [ST_W-1:0]   new_state;
    logic [VER_W-1:0]  new_version;

    modport source (output valid, func, device, read_access, write_access, new_state,
                    new_version, input ready);
    modport sink   (input valid, func, device, read_access, write_access, new_state,
                    new_version, output ready);
endinterface

interface mdcd_rsp_if import mdcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              transfer_needed;
    logic [DEV_W-1:0]  source_device;
    logic [ST_W-1:0]   copy_state_out;
    logic [VER_W-1:0]  copy_version_out;
    logic [RDR_W-1:0]  readers_out;
    logic              owner_valid;
    logic [DEV_W-1:0]  owner_out;

    modport source (output valid, status, transfer_needed, source_device, copy_state_out,
                    copy_version_out, readers_out, owner_valid, owner_out, input ready);
    modport sink   (input valid, status, transfer_needed, source_device, copy_state_out,
                    copy_version_out, readers_out, owner_valid, owner_out, output ready);
endinterface

interface mdcd_cfg_if import mdcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] num_devices;

    modport source (output valid, num_devices, input ready);
    modport sink   (input valid, num_devices, output ready);
endinterface

/* hdl/mdcd_scan_unit.sv */
// shared per-entry evaluation used by the acquire scan: version compare and state update
`timescale 1ns / 1ps
module mdcd_scan_unit import mdcd_pkg::*; (
    input  t_scan_ctrl       i_ctrl,
    input  logic [ST_W-1:0]  i_state,
    input  logic [VER_W-1:0] i_version,
    output t_scan_res        o_res
);

    logic [VER_W:0] w_diff;
    logic           w_lt;
    logic           w_gt;
    logic           w_valid;

    // one subtractor gives both orderings of the entry version against the acquiring copy
    assign w_diff  = {1'b0, i_version} - {1'b0, i_ctrl.cver};
    assign w_lt    = w_diff[VER_W];
    assign w_gt    = !w_lt && (w_diff[VER_W-1:0] != '0);
    assign w_valid = (i_state != CS_INVALID);

    // state update for a copy other than the acquiring one
    always_comb begin
        o_res.new_state   = i_state;
        o_res.valid_src   = w_valid;
        o_res.owned_newer = (i_state == CS_OWNED) && w_gt;
        o_res.clr_owner   = w_valid && i_ctrl.rd && !i_ctrl.wr && (i_ctrl.cs == CS_OWNED);
        if (w_valid) begin
            if (i_ctrl.wr) begin
                o_res.new_state = CS_SHARED;
            end else if (i_ctrl.rd) begin
                if (i_ctrl.cs == CS_OWNED && w_lt) begin
                    o_res.new_state = CS_INVALID;
                end else if (i_state == CS_EXCLUSIVE) begin
                    o_res.new_state = CS_SHARED;
                end
            end
        end
    end

endmodule

/* hdl/multi_device_coherence_directory.sv */
// coherence directory top level: sequencer, entry memory and owner record
// Sequence: attach, detach and rejected requests go from accept through check to done;
//   set adds a load step; acquire adds a load, a scan with a read and a write step per
//   present copy visited and a read step per other active slot, and a final step.
// Throughput: one request at a time; the next request is taken once the result is
//   handed to the output register, which may still wait on the response channel.
// Reset: synchronous active low; clears presence bits, owner record and device count
//   (back to 8); entry memory contents are don't-care until a copy is attached.
`timescale 1ns / 1ps
module multi_device_coherence_directory import mdcd_pkg::*; #(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mdcd_req_if.sink     i_req,
    mdcd_rsp_if.source   o_rsp,
    mdcd_cfg_if.sink     i_cfg
);

    localparam int IdxW = $clog2(MAX_DEVICES);
    localparam int CntW = $clog2(MAX_DEVICES + 1);
    localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_WR,
        S_FINAL,
        S_DONE
    } t_state;

    // sequencer and configuration
    t_state                 r_state,      n_state;
    logic [CFG_W-1:0]       r_num_dev,    n_num_dev;
    logic [MAX_DEVICES-1:0] r_present,    n_present;
    logic                   r_owner_set,  n_owner_set;
    logic [DEV_W-1:0]       r_owner_idx,  n_owner_idx;
    logic                   r_out_valid,  n_out_valid;

    // latched request
    logic [FUNC_W-1:0]      r_func,       n_func;
    logic [CmpW-1:0]        r_dev,        n_dev;
    logic                   r_rd,         n_rd;
    logic                   r_wr,         n_wr;
    logic [ST_W-1:0]        r_nst,        n_nst;
    logic [VER_W-1:0]       r_nver,       n_nver;

    // acquire working registers
    logic [ST_W-1:0]        r_cs,         n_cs;
    logic [VER_W-1:0]       r_cver,       n_cver;
    logic [RDR_W-1:0]       r_crd,        n_crd;
    logic                   r_need,       n_need;
    logic                   r_have_src,   n_have_src;
    logic [DEV_W-1:0]       r_cand,       n_cand;
    logic                   r_own_clr,    n_own_clr;
    logic [CmpW-1:0]        r_i,          n_i;

    // result staging and output register
    t_result                r_res,        n_res;
    t_result                r_out,        n_out;
    logic                   r_out_own_v,  n_out_own_v;
    logic [DEV_W-1:0]       r_out_own,    n_out_own;

    // entry memory
    t_entry                 r_mem [MAX_DEVICES];
    t_entry                 r_rdata;
    logic                   w_mem_we;
    logic [IdxW-1:0]        w_mem_waddr;
    logic [IdxW-1:0]        w_mem_raddr;
    t_entry                 w_mem_wdata;

    logic [CmpW-1:0]        w_n;
    logic [CmpW-1:0]        w_cfg_ext;
    logic [CmpW-1:0]        w_max_ext;
    logic [CmpW-1:0]        w_cand_ext;
    logic [IdxW-1:0]        w_didx;
    logic [IdxW-1:0]        w_iidx;
    logic [IdxW-1:0]        w_cidx;
    t_scan_ctrl             w_ctrl;
    t_scan_res              w_scan;
    logic                   w_need_f;
    logic                   w_src_ok;
    logic [ST_W-1:0]        w_fin_state;
    logic [RDR_W-1:0]       w_fin_readers;

    // effective device count and slot indices
    assign w_cfg_ext  = CmpW'(r_num_dev);
    assign w_max_ext  = CmpW'(MAX_DEVICES);
    assign w_n        = (w_cfg_ext < w_max_ext) ? w_cfg_ext : w_max_ext;
    assign w_cand_ext = CmpW'(r_cand);
    assign w_didx     = r_dev[IdxW-1:0];
    assign w_iidx     = r_i[IdxW-1:0];
    assign w_cidx     = w_cand_ext[IdxW-1:0];

    // shared scan unit
    assign w_ctrl = '{cs: r_cs, cver: r_cver, rd: r_rd, wr: r_wr};

    mdcd_scan_unit u_scan (
        .i_ctrl    (w_ctrl),
        .i_state   (r_rdata.state),
        .i_version (r_rdata.version),
        .o_res     (w_scan)
    );

    // acquire wrap-up terms
    assign w_need_f = r_need && r_rd;
    assign w_src_ok = r_have_src && (w_cand_ext < w_n) && (w_cand_ext != r_dev)
                      && r_present[w_cidx];
    assign w_fin_state   = r_wr ? CS_OWNED : (r_rd ? CS_SHARED : r_cs);
    assign w_fin_readers = (r_rd && (r_crd != '1)) ? (r_crd + RDR_W'(1)) : r_crd;

    // handshakes and output payload
    assign i_req.ready            = (r_state == S_IDLE);
    assign i_cfg.ready            = 1'b1;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out.status;
    assign o_rsp.transfer_needed  = r_out.xfer;
    assign o_rsp.source_device    = r_out.src;
    assign o_rsp.copy_state_out   = r_out.state;
    assign o_rsp.copy_version_out = r_out.version;
    assign o_rsp.readers_out      = r_out.readers;
    assign o_rsp.owner_valid      = r_out_own_v;
    assign o_rsp.owner_out        = r_out_own;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_num_dev   = r_num_dev;
        n_present   = r_present;
        n_owner_set = r_owner_set;
        n_owner_idx = r_owner_idx;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_dev       = r_dev;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_nst       = r_nst;
        n_nver      = r_nver;
        n_cs        = r_cs;
        n_cver      = r_cver;
        n_crd       = r_crd;
        n_need      = r_need;
        n_have_src  = r_have_src;
        n_cand      = r_cand;
        n_own_clr   = r_own_clr;
        n_i         = r_i;
        n_res       = r_res;
        n_out       = r_out;
        n_out_own_v = r_out_own_v;
        n_out_own   = r_out_own;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_didx;
        w_mem_raddr = w_didx;
        w_mem_wdata = r_rdata;

        if (i_cfg.valid) begin
            n_num_dev = i_cfg.num_devices;
        end
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_dev   = CmpW'(i_req.device);
                    n_rd    = i_req.read_access;
                    n_wr    = i_req.write_access;
                    n_nst   = i_req.new_state;
                    n_nver  = i_req.new_version;
                    n_state = S_CHECK;
                end
            end
            // range and presence checks, attach and detach finish here
            S_CHECK: begin
                n_res = '0;
                if (r_dev >= w_n) begin
                    n_res.status = STS_RANGE;
                    n_state      = S_DONE;
                end else begin
                    unique case (r_func) inside
                        FN_ATTACH: begin
                            n_present[w_didx] = 1'b1;
                            w_mem_we          = 1'b1;
                            w_mem_wdata       = '0;
                            n_state           = S_DONE;
                        end
                        FN_DETACH: begin
                            if (!r_present[w_didx]) begin
                                n_res.status = STS_NO_COPY;
                            end else begin
                                n_present[w_didx] = 1'b0;
                            end
                            n_state = S_DONE;
                        end
                        FN_SET, FN_ACQUIRE: begin
                            if (!r_present[w_didx]) begin
                                n_res.status = STS_NO_COPY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                    endcase
                end
            end
            // addressed entry is in the read register
            S_LOAD: begin
                if (r_func == FN_SET) begin
                    w_mem_we          = 1'b1;
                    w_mem_wdata.state   = r_nst;
                    w_mem_wdata.version = r_nver;
                    n_res.state       = r_nst;
                    n_res.version     = r_nver;
                    n_res.readers     = r_rdata.readers;
                    n_state           = S_DONE;
                end else begin
                    n_cs       = r_rdata.state;
                    n_cver     = r_rdata.version;
                    n_crd      = r_rdata.readers;
                    n_need     = (r_rdata.state == CS_INVALID);
                    n_have_src = r_owner_set;
                    n_cand     = r_owner_idx;
                    n_own_clr  = 1'b0;
                    n_i        = '0;
                    n_state    = S_SCAN_RD;
                end
            end
            // pick the next present copy other than the addressed one
            S_SCAN_RD: begin
                if (r_i >= w_n) begin
                    n_state = S_FINAL;
                end else if (r_i == r_dev || !r_present[w_iidx]) begin
                    n_i = r_i + CmpW'(1);
                end else begin
                    w_mem_raddr = w_iidx;
                    n_state     = S_SCAN_WR;
                end
            end
            // evaluate the visited copy and write back its new state
            S_SCAN_WR: begin
                w_mem_we          = 1'b1;
                w_mem_waddr       = w_iidx;
                w_mem_wdata.state = w_scan.new_state;
                if (r_cs == CS_INVALID && !r_owner_set && w_scan.valid_src) begin
                    n_have_src = 1'b1;
                    n_cand     = r_i[DEV_W-1:0];
                end
                if (r_cs == CS_SHARED && w_scan.owned_newer) begin
                    n_need = 1'b1;
                end
                if (w_scan.clr_owner) begin
                    n_own_clr = 1'b1;
                end
                n_i     = r_i + CmpW'(1);
                n_state = S_SCAN_RD;
            end
            // update the addressed copy and the owner, decide the transfer
            S_FINAL: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = '{state: w_fin_state, version: r_cver, readers: w_fin_readers};
                if (r_wr) begin
                    n_owner_set = 1'b1;
                    n_owner_idx = r_dev[DEV_W-1:0];
                end else if (r_own_clr) begin
                    n_owner_set = 1'b0;
                    n_owner_idx = '0;
                end
                n_res.status  = (w_need_f && !w_src_ok) ? STS_NO_SOURCE : STS_OK;
                n_res.xfer    = w_need_f;
                n_res.src     = (w_need_f && w_src_ok) ? r_cand : '0;
                n_res.state   = w_fin_state;
                n_res.version = r_cver;
                n_res.readers = w_fin_readers;
                n_state       = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_own_v = r_owner_set;
                    n_out_own   = r_owner_set ? r_owner_idx : '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_dev   <= CFG_NUM_DEV_RST;
            r_present   <= '0;
            r_owner_set <= 1'b0;
            r_owner_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num_dev   <= n_num_dev;
            r_present   <= n_present;
            r_owner_set <= n_owner_set;
            r_owner_idx <= n_owner_idx;
            r_out_valid <= n_out_valid;
            r_func      <= n_func;
            r_dev       <= n_dev;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_nst       <= n_nst;
            r_nver      <= n_nver;
            r_cs        <= n_cs;
            r_cver      <= n_cver;
            r_crd       <= n_crd;
            r_need      <= n_need;
            r_have_src  <= n_have_src;
            r_cand      <= n_cand;
            r_own_clr   <= n_own_clr;
            r_i         <= n_i;
            r_res       <= n_res;
            r_out       <= n_out;
            r_out_own_v <= n_out_own_v;
            r_out_own   <= n_out_own;
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_mem_raddr];
    end

endmodule

/* hdl/mdcd_checker.sv */
// port-level checks on the coherence directory, bound to the top level
`timescale 1ns / 1ps
module mdcd_checker import mdcd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [STAT_W-1:0] i_status,
    input logic              i_xfer,
    input logic [DEV_W-1:0]  i_src,
    input logic [ST_W-1:0]   i_state,
    input logic [VER_W-1:0]  i_version,
    input logic [RDR_W-1:0]  i_readers,
    input logic              i_owner_v,
    input logic [DEV_W-1:0]  i_owner
);

    // a pending response stays up until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // one request at a time: no second accept right after the first
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // rejected requests show an empty copy
    a_reject_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == STS_RANGE || i_status == STS_NO_COPY)
        |-> (i_state == CS_INVALID && i_version == '0 && i_readers == '0 && !i_xfer))
        else $error("rejected request shows copy data");

    // source only reported with a transfer, missing source implies a transfer
    a_xfer_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_xfer || i_src == '0) && (i_status != STS_NO_SOURCE || i_xfer)
        && (i_status != STS_NO_SOURCE || i_src == '0)))
        else $error("transfer and source fields disagree");

    // owner index reads zero when no owner is recorded
    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_owner_v |-> i_owner == '0)
        else $error("owner index without owner");

endmodule

bind multi_device_coherence_directory mdcd_checker u_mdcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_xfer      (o_rsp.transfer_needed),
    .i_src       (o_rsp.source_device),
    .i_state     (o_rsp.copy_state_out),
    .i_version   (o_rsp.copy_version_out),
    .i_readers   (o_rsp.readers_out),
    .i_owner_v   (o_rsp.owner_valid),
    .i_owner     (o_rsp.owner_out)
);
